### hdl/equivalence_class_table_unit_assert.svh
// ---------------------------------------------------------------------------
// Equivalence class table assertion macros
// Shared property templates for the equivalence class table unit.
// ---------------------------------------------------------------------------
`ifndef EQUIVALENCE_CLASS_TABLE_UNIT_ASSERT_SVH
`define EQUIVALENCE_CLASS_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ECT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ECT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ect_pkg.sv
// ---------------------------------------------------------------------------
// Equivalence class table package
// Field widths, action codes, controller states and defaults.
// ---------------------------------------------------------------------------
package ect_pkg;

   localparam int IDX_W          = 6;
   localparam int LABEL_W        = 6;
   localparam int POS_W          = 7;
   localparam int ACTION_W       = 2;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 24;
   localparam int NUM_ELEMENTS_DEF = 64;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_MERGE = 2'd1,
      ACT_LIST  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LABEL_A,
      ST_LABEL_B,
      ST_SWEEP,
      ST_FLUSH,
      ST_ACK
   } state_type;

endpackage

### hdl/ect_ram.sv
// ---------------------------------------------------------------------------
// Equivalence class table RAM
// Simple dual-port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module ect_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/equivalence_class_table_unit.sv
// ---------------------------------------------------------------------------
// Equivalence class table unit
// Quick-find class table: clear, merge two classes, list members of a class.
// ---------------------------------------------------------------------------
//   Channel   Direction  Beat contents
//   req_*     in         tuser: action; tdata: first_element, second_element
//   rsp_*     out        tdata: member, class_label, position; tlast: last
//
// A clear goes straight to its final beat; a merge reads two labels and a list
// one before the sweep. The sweep reads one entry per cycle through the label
// RAM port unless a list stalls it, and drains its reads in flight before the
// final beat. A list stalls its sweep while it holds a member to emit and the
// output register is full and not taken, and the final beat of every clear,
// merge and list waits for that register too. Reset and clear act at once
// through one valid bit per entry; an entry that is not valid reads as its
// own index. One request is in progress at a time.
// ---------------------------------------------------------------------------
`include "equivalence_class_table_unit_assert.svh"

module equivalence_class_table_unit #(
   parameter int NUM_ELEMENTS = ect_pkg::NUM_ELEMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [5:0] first_element, [11:6] second_element, [15:12] zero
   input  logic [ect_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [ect_pkg::ACTION_W-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [5:0] member, [11:6] class_label, [18:12] position, [23:19] zero
   output logic [ect_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int ADDR_W = $clog2(NUM_ELEMENTS);
   localparam int CNT_W  = $clog2(NUM_ELEMENTS + 1);
   localparam int IDX_W  = ect_pkg::IDX_W;
   localparam int LBL_W  = ect_pkg::LABEL_W;
   localparam int POS_W  = ect_pkg::POS_W;

   ect_pkg::state_type  state_ff, state_in;
   ect_pkg::action_type act_ff;
   logic [ADDR_W-1:0]   b_ff;
   logic [LBL_W-1:0]    target_ff, ack_label_ff;
   logic [NUM_ELEMENTS-1:0] vld_ff;
   logic                rd_vbit_ff;
   logic [LBL_W-1:0]    rd_tag_ff;
   logic [CNT_W-1:0]    rd_idx_ff;
   logic                chk_ff;
   logic                pend_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_member_ff;
   logic [LBL_W-1:0]    rsp_label_ff;
   logic [POS_W-1:0]    rsp_pos_ff;
   logic                rsp_last_ff;

   ect_pkg::action_type req_action;
   logic [IDX_W-1:0]    req_first, req_second, first_cl, second_cl;
   logic                accept, out_free;
   logic [LBL_W-1:0]    ram_q, eff, eff_a_lo, eff_a_hi;
   logic                match, chk_stall, proc, advance, issue_more, sweep_done;
   logic                rd_en, wr_en, push, push_last;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [IDX_W-1:0]    push_member;
   logic [LBL_W-1:0]    push_label;
   logic [POS_W-1:0]    push_pos;

   assign req_action = ect_pkg::action_type'(req_tuser);
   assign req_first  = req_tdata[IDX_W-1:0];
   assign req_second = req_tdata[2*IDX_W-1:IDX_W];
   assign first_cl   = ({1'b0, req_first} >= (IDX_W+1)'(NUM_ELEMENTS))
                       ? IDX_W'(NUM_ELEMENTS - 1) : req_first;
   assign second_cl  = ({1'b0, req_second} >= (IDX_W+1)'(NUM_ELEMENTS))
                       ? IDX_W'(NUM_ELEMENTS - 1) : req_second;

   assign req_tready = (state_ff == ect_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign eff        = rd_vbit_ff ? ram_q : rd_tag_ff;
   assign match      = (eff == target_ff);
   assign eff_a_lo   = (target_ff > eff) ? eff : target_ff;
   assign eff_a_hi   = (target_ff > eff) ? target_ff : eff;
   assign chk_stall  = (act_ff == ect_pkg::ACT_LIST) && match && pend_ff && !out_free;
   assign proc       = (state_ff == ect_pkg::ST_SWEEP) && chk_ff && !chk_stall;
   assign advance    = (state_ff == ect_pkg::ST_SWEEP) && !(chk_ff && chk_stall);
   assign issue_more = (rd_idx_ff < CNT_W'(NUM_ELEMENTS));
   assign sweep_done = !issue_more && !chk_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ect_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ect_pkg::ACT_CLEAR: state_in = ect_pkg::ST_ACK;
                  ect_pkg::ACT_MERGE: state_in = ect_pkg::ST_LABEL_A;
                  ect_pkg::ACT_LIST:  state_in = ect_pkg::ST_LABEL_A;
                  default:            state_in = ect_pkg::ST_IDLE;
               endcase
            end
         end
         ect_pkg::ST_LABEL_A: begin
            state_in = (act_ff == ect_pkg::ACT_MERGE) ? ect_pkg::ST_LABEL_B
                                                      : ect_pkg::ST_SWEEP;
         end
         ect_pkg::ST_LABEL_B: state_in = ect_pkg::ST_SWEEP;
         ect_pkg::ST_SWEEP: begin
            if (sweep_done) begin
               state_in = (act_ff == ect_pkg::ACT_LIST) ? ect_pkg::ST_FLUSH
                                                        : ect_pkg::ST_ACK;
            end
         end
         ect_pkg::ST_FLUSH, ect_pkg::ST_ACK: begin
            if (out_free) begin
               state_in = ect_pkg::ST_IDLE;
            end
         end
         default: state_in = ect_pkg::ST_IDLE;
      endcase
   end

   // Memory and output controls.
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = rd_tag_ff[ADDR_W-1:0];
      push        = 1'b0;
      push_member = '0;
      push_label  = target_ff;
      push_pos    = pos_ff;
      push_last   = 1'b0;
      unique case (state_ff)
         ect_pkg::ST_IDLE: begin
            if (accept && (req_action == ect_pkg::ACT_MERGE ||
                           req_action == ect_pkg::ACT_LIST)) begin
               rd_en   = 1'b1;
               rd_addr = first_cl[ADDR_W-1:0];
            end
         end
         ect_pkg::ST_LABEL_A: begin
            if (act_ff == ect_pkg::ACT_MERGE) begin
               rd_en   = 1'b1;
               rd_addr = b_ff;
            end
         end
         ect_pkg::ST_SWEEP: begin
            if (advance && issue_more) begin
               rd_en   = 1'b1;
               rd_addr = rd_idx_ff[ADDR_W-1:0];
            end
            if (proc && match) begin
               if (act_ff == ect_pkg::ACT_MERGE) begin
                  wr_en = 1'b1;
               end else if (pend_ff) begin
                  push        = 1'b1;
                  push_member = pend_idx_ff;
               end
            end
         end
         ect_pkg::ST_FLUSH: begin
            push        = out_free;
            push_member = pend_idx_ff;
            push_last   = 1'b1;
         end
         ect_pkg::ST_ACK: begin
            push       = out_free;
            push_label = ack_label_ff;
            push_pos   = POS_W'(1);
            push_last  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   ect_ram #(
      .WIDTH (LBL_W),
      .DEPTH (NUM_ELEMENTS)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ack_label_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ect_pkg::ST_IDLE;
         act_ff       <= ect_pkg::ACT_NONE;
         vld_ff       <= '0;
         rd_idx_ff    <= '0;
         chk_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            act_ff <= req_action;
            if (req_action == ect_pkg::ACT_CLEAR) begin
               vld_ff <= '0;
            end
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (state_ff == ect_pkg::ST_LABEL_A || state_ff == ect_pkg::ST_LABEL_B) begin
            rd_idx_ff <= '0;
            chk_ff    <= 1'b0;
            pend_ff   <= 1'b0;
            pos_ff    <= '0;
         end else if (advance) begin
            chk_ff <= issue_more;
            if (issue_more) begin
               rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            end
         end
         if (proc && match && act_ff == ect_pkg::ACT_LIST) begin
            pend_ff <= 1'b1;
            pos_ff  <= pos_ff + POS_W'(1);
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         b_ff         <= second_cl[ADDR_W-1:0];
         ack_label_ff <= LBL_W'(first_cl);
      end
      if (state_ff == ect_pkg::ST_LABEL_A) begin
         target_ff <= eff;
      end
      if (state_ff == ect_pkg::ST_LABEL_B) begin
         target_ff    <= eff_a_hi;
         ack_label_ff <= eff_a_lo;
      end
      if (rd_en) begin
         rd_vbit_ff <= vld_ff[rd_addr];
         rd_tag_ff  <= LBL_W'(rd_addr);
      end
      if (proc && match && act_ff == ect_pkg::ACT_LIST) begin
         pend_idx_ff <= IDX_W'(rd_tag_ff);
      end
      if (push) begin
         rsp_member_ff <= push_member;
         rsp_label_ff  <= push_label;
         rsp_pos_ff    <= push_pos;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(ect_pkg::RSP_DATA_W - IDX_W - LBL_W - POS_W)'(0),
                        rsp_pos_ff, rsp_label_ff, rsp_member_ff};

   `ECT_ASSERT_NEXT(a_req_leaves_idle, clock, reset,
      accept && req_action != ect_pkg::ACT_NONE, state_ff != ect_pkg::ST_IDLE,
      "Accepted request did not start work.")
   `ECT_ASSERT_NOW(a_flush_has_member, clock, reset,
      state_ff == ect_pkg::ST_FLUSH, pend_ff,
      "List finished without a pending member.")
   `ECT_ASSERT_NOW(a_count_bounded, clock, reset,
      state_ff == ect_pkg::ST_SWEEP, pos_ff <= POS_W'(NUM_ELEMENTS),
      "Member count exceeds table size.")
   `ECT_ASSERT_NOW(a_push_has_room, clock, reset,
      push, out_free,
      "Result written over an untaken beat.")

endmodule

### bench/testbench.sv
// ---------------------------------------------------------------------------
// Equivalence class table unit testbench
// Drives clear, merge, list and no-action requests with random gaps on both streams,
// tracks the label table alongside the unit and checks every response beat
// field by field against the predicted member lists and acknowledgements.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_EL = ect_pkg::NUM_ELEMENTS_DEF;

   typedef struct packed {
      ect_pkg::action_type              action;
      logic [ect_pkg::IDX_W-1:0]        first_element;
      logic [ect_pkg::IDX_W-1:0]        second_element;
   } table_request_type;

   typedef struct packed {
      logic [ect_pkg::IDX_W-1:0]   member;
      logic [ect_pkg::LABEL_W-1:0] class_label;
      logic [ect_pkg::POS_W-1:0]   position;
      logic                        last;
   } class_result_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ect_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ect_pkg::ACTION_W-1:0]   req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ect_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   table_request_type pending_requests[$];
   class_result_type  expected_results[$];
   logic [ect_pkg::LABEL_W-1:0] class_of[NUM_EL];

   int req_beats_offered = 0;
   int req_beats_taken = 0;
   int results_seen = 0;
   int mismatches = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int clears_seen = 0;
   int merges_seen = 0;
   int lists_seen = 0;
   int ignored_seen = 0;
   int longest_list = 0;

   equivalence_class_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void predict_class_results(table_request_type rq);
      logic [ect_pkg::IDX_W-1:0]   a;
      logic [ect_pkg::IDX_W-1:0]   b;
      logic [ect_pkg::LABEL_W-1:0] hi;
      logic [ect_pkg::LABEL_W-1:0] lo;
      logic [ect_pkg::LABEL_W-1:0] want;
      int                          count;
      int                          pos;
      a = (rq.first_element >= NUM_EL) ? ect_pkg::IDX_W'(NUM_EL - 1) : rq.first_element;
      b = (rq.second_element >= NUM_EL) ? ect_pkg::IDX_W'(NUM_EL - 1) : rq.second_element;
      case (rq.action)
         ect_pkg::ACT_CLEAR: begin
            for (int i = 0; i < NUM_EL; i++) class_of[i] = ect_pkg::LABEL_W'(i);
            expected_results.push_back('{'0, class_of[a], ect_pkg::POS_W'(1), 1'b1});
            clears_seen++;
         end
         ect_pkg::ACT_MERGE: begin
            hi = (class_of[a] > class_of[b]) ? class_of[a] : class_of[b];
            lo = (class_of[a] > class_of[b]) ? class_of[b] : class_of[a];
            for (int i = 0; i < NUM_EL; i++) begin
               if (class_of[i] == hi) class_of[i] = lo;
            end
            expected_results.push_back('{'0, lo, ect_pkg::POS_W'(1), 1'b1});
            merges_seen++;
         end
         ect_pkg::ACT_LIST: begin
            want = class_of[a];
            count = 0;
            pos = 0;
            for (int i = 0; i < NUM_EL; i++) begin
               if (class_of[i] == want) count++;
            end
            for (int i = 0; i < NUM_EL; i++) begin
               if (class_of[i] == want) begin
                  pos++;
                  expected_results.push_back('{ect_pkg::IDX_W'(i), want,
                                               ect_pkg::POS_W'(pos), pos == count});
               end
            end
            if (count > longest_list) longest_list = count;
            lists_seen++;
         end
         default: ignored_seen++;
      endcase
   endfunction

   function automatic void queue_request(ect_pkg::action_type act,
                                         logic [ect_pkg::IDX_W-1:0] a,
                                         logic [ect_pkg::IDX_W-1:0] b);
      pending_requests.push_back('{act, a, b});
   endfunction

   function automatic logic [ect_pkg::IDX_W-1:0] pick_element();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return ect_pkg::IDX_W'($urandom_range(0, NUM_EL - 1));
   endfunction

   task automatic wait_until_drained();
      @(posedge clock);
      while (pending_requests.size() != 0 || req_beats_offered != req_beats_taken ||
             expected_results.size() != 0)
         @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_requests
      table_request_type rq;
      bit                rest;
      rest = ($urandom_range(0, 99) < 17) &&
             !(req_beats_offered >= 200 && req_beats_offered < 280);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beats_taken == req_beats_offered) begin
         if (pending_requests.size() != 0 && !rest) begin
            rq = pending_requests.pop_front();
            req_tdata <= {4'b0, rq.second_element, rq.first_element};
            req_tuser <= rq.action;
            req_tvalid <= 1'b1;
            req_beats_offered <= req_beats_offered + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_response_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 150) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (results_seen >= 400 && results_seen < 700) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 17);
      end
   end

   always @(posedge clock) begin : observe
      class_result_type got;
      class_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[5:0], rsp_tdata[11:6], rsp_tdata[18:12], rsp_tlast};
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $error("response beat with nothing expected: member %0d label %0d",
                      got.member, got.class_label);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got.member !== want.member) begin
                  $error("member: expected %0d, actual %0d", want.member, got.member);
                  mismatches++;
               end
               if (got.class_label !== want.class_label) begin
                  $error("class_label: expected %0d, actual %0d",
                         want.class_label, got.class_label);
                  mismatches++;
               end
               if (got.position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position, got.position);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, got.last);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_class_results('{ect_pkg::action_type'(req_tuser), req_tdata[5:0],
                                    req_tdata[11:6]});
            req_beats_taken <= req_beats_taken + 1;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int random_items;
      int episode;
      int ops;
      int r;
      for (int i = 0; i < NUM_EL; i++) class_of[i] = ect_pkg::LABEL_W'(i);
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      queue_request(ect_pkg::ACT_CLEAR, 6'd0, 6'd63);
      queue_request(ect_pkg::ACT_CLEAR, 6'd63, 6'd0);
      queue_request(ect_pkg::ACT_LIST, 6'd0, 6'd63);
      queue_request(ect_pkg::ACT_LIST, 6'd63, 6'd0);
      queue_request(ect_pkg::ACT_MERGE, 6'd0, 6'd63);
      queue_request(ect_pkg::ACT_LIST, 6'd63, 6'd21);
      queue_request(ect_pkg::ACT_MERGE, 6'd63, 6'd0);
      queue_request(ect_pkg::ACT_MERGE, 6'd62, 6'd61);
      queue_request(ect_pkg::ACT_MERGE, 6'd62, 6'd63);
      queue_request(ect_pkg::ACT_LIST, 6'd62, 6'd42);
      queue_request(ect_pkg::ACT_MERGE, 6'd5, 6'd5);
      queue_request(ect_pkg::ACT_NONE, 6'd63, 6'd63);
      queue_request(ect_pkg::ACT_NONE, 6'd0, 6'd0);
      queue_request(ect_pkg::ACT_LIST, 6'd5, 6'd63);
      queue_request(ect_pkg::ACT_MERGE, 6'd32, 6'd31);
      queue_request(ect_pkg::ACT_MERGE, 6'd1, 6'd2);
      queue_request(ect_pkg::ACT_LIST, 6'd2, 6'd0);
      queue_request(ect_pkg::ACT_CLEAR, 6'd42, 6'd21);
      queue_request(ect_pkg::ACT_LIST, 6'd61, 6'd0);
      queue_request(ect_pkg::ACT_MERGE, 6'd63, 6'd0);
      queue_request(ect_pkg::ACT_LIST, 6'd0, 6'd63);
      wait_until_drained();

      random_items = 0;
      episode = 0;
      while (random_items < 390) begin
         queue_request(ect_pkg::ACT_CLEAR, pick_element(), pick_element());
         random_items++;
         if (episode == 3) begin
            for (int i = 0; i < NUM_EL - 1; i++) begin
               queue_request(ect_pkg::ACT_MERGE, ect_pkg::IDX_W'(i + 1),
                             ect_pkg::IDX_W'(i));
            end
            queue_request(ect_pkg::ACT_LIST, pick_element(), pick_element());
            queue_request(ect_pkg::ACT_LIST, 6'd63, pick_element());
            random_items += NUM_EL + 1;
         end else begin
            ops = $urandom_range(10, 70);
            if (ops > 390 - random_items) ops = 390 - random_items;
            for (int k = 0; k < ops; k++) begin
               r = $urandom_range(0, 99);
               if (r < 52) begin
                  queue_request(ect_pkg::ACT_MERGE, pick_element(), pick_element());
               end else if (r < 95) begin
                  queue_request(ect_pkg::ACT_LIST, pick_element(), pick_element());
               end else begin
                  queue_request(ect_pkg::ACT_NONE, pick_element(), pick_element());
               end
               random_items++;
            end
         end
         episode++;
         if (episode == 5) wait_until_drained();
      end

      wait_until_drained();
      repeat (100) @(posedge clock);
      $display("Covered %0d clears, %0d merges, %0d lists and %0d ignored beats.",
               clears_seen, merges_seen, lists_seen, ignored_seen);
      $display("Checked %0d response beats; the longest member list had %0d entries.",
               results_seen, longest_list);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
